FILE: rtl/spp_pkg.sv
package spp_pkg;

	localparam int MAX_WIDTH_DEF = 64;

	localparam int DATA_W    = 32;
	localparam int ACC_W     = 64;
	localparam int ROW_W     = 32;
	localparam int WIN_W     = 33;
	localparam int COLF_W    = 6;
	localparam int WIDTHF_W  = 7;
	localparam int QUOT_W    = 80;
	localparam int IN_TDATA_W  = 32;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 72;
	localparam int CFG_IDX_W   = 2;

	localparam int SQ_STEPS  = 32;
	localparam int DIV_STEPS = 80;

	// tuser bit positions on the input side
	localparam int USER_EMPTY = 0;
	localparam int USER_BATCH = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_POOL_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL_VALUE = 2'd2;

	localparam logic [2:0] MODE_SUM    = 3'd0;
	localparam logic [2:0] MODE_AVG    = 3'd1;
	localparam logic [2:0] MODE_SQRT   = 3'd2;
	localparam logic [2:0] MODE_MAX    = 3'd3;
	localparam logic [2:0] MODE_MIN    = 3'd4;
	localparam logic [2:0] MODE_FIRST  = 3'd5;
	localparam logic [2:0] MODE_LAST   = 3'd6;
	localparam logic [2:0] MODE_UNUSED = 3'd7;

	localparam logic [ROW_W-1:0]  ROWS_CAP = 32'hFFFF_FFFE;
	localparam logic [DATA_W-1:0] Q_MAX32  = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] Q_MIN32  = 32'h8000_0000;
	localparam logic [ACC_W-1:0]  ACC_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [ACC_W-1:0]  ACC_MIN  = 64'h8000_0000_0000_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_FIN,
		ST_WAIT,
		ST_PAD,
		ST_EMIT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		IT_IDLE,
		IT_SQRT,
		IT_DIV
	} iter_phase_t;

	typedef struct packed {
		logic accept;
		logic update;
		logic start_iter;
		logic load_plain;
		logic load_iter;
		logic load_pad;
	} spp_cmd_t;

	typedef struct packed {
		logic in_empty;
		logic last;
		logic plain;
		logic iter_done;
		logic out_xfer;
		logic out_valid;
		logic pad_more;
	} spp_sts_t;

endpackage

FILE: rtl/spp_ram.sv
module spp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/spp_iter.sv
// Shared iterative unit: optional integer square root (2 bits per step),
// then restoring division (1 quotient bit per step).
module spp_iter import spp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              op_sqrt,
	input  logic [ACC_W-1:0]  mag,
	input  logic [ROW_W-1:0]  n,
	output logic [QUOT_W-1:0] quot,
	output logic              done
);

	iter_phase_t        phase_q;
	logic [6:0]         cnt_q;
	logic               done_q;
	logic [ACC_W-1:0]   x_q;
	logic [35:0]        rem_q;
	logic [31:0]        root_q;
	logic [ACC_W-1:0]   mag_q;
	logic [QUOT_W-1:0]  quot_q;
	logic [31:0]        rmd_q;
	logic [31:0]        dvs_q;

	logic [35:0] rem_n;
	logic [35:0] trial;
	logic        sq_ge;
	logic [31:0] root_n;
	logic [32:0] dv_r;
	logic [32:0] dv_sub;
	logic        dv_ge;

	always_comb begin
		rem_n  = {rem_q[33:0], x_q[63:62]};
		trial  = {2'b00, root_q, 2'b01};
		sq_ge  = rem_n >= trial;
		root_n = {root_q[30:0], sq_ge};
		dv_r   = {rmd_q, quot_q[QUOT_W-1]};
		dv_sub = dv_r - {1'b0, dvs_q};
		dv_ge  = dv_r >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= IT_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				IT_IDLE: begin
					if (start) begin
						phase_q <= op_sqrt ? IT_SQRT : IT_DIV;
						cnt_q   <= op_sqrt ? 7'(SQ_STEPS - 1) : 7'(DIV_STEPS - 1);
					end
				end
				IT_SQRT: begin
					if (cnt_q == '0) begin
						phase_q <= IT_DIV;
						cnt_q   <= 7'(DIV_STEPS - 1);
					end else begin
						cnt_q <= cnt_q - 7'd1;
					end
				end
				IT_DIV: begin
					if (cnt_q == '0) begin
						phase_q <= IT_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 7'd1;
					end
				end
				default: phase_q <= IT_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			IT_IDLE: begin
				if (start) begin
					mag_q  <= mag;
					x_q    <= {n, 32'b0};
					rem_q  <= '0;
					root_q <= '0;
					quot_q <= {16'b0, mag + ACC_W'(n[31:1])};
					dvs_q  <= n;
					rmd_q  <= '0;
				end
			end
			IT_SQRT: begin
				x_q    <= {x_q[61:0], 2'b00};
				rem_q  <= sq_ge ? (rem_n - trial) : rem_n;
				root_q <= root_n;
				if (cnt_q == '0) begin
					// dividend = mag * 2^16 + s/2, divisor = s
					quot_q <= {mag_q, 16'b0} + QUOT_W'(root_n[31:1]);
					dvs_q  <= root_n;
					rmd_q  <= '0;
				end
			end
			IT_DIV: begin
				rmd_q  <= dv_ge ? dv_sub[31:0] : dv_r[31:0];
				quot_q <= {quot_q[QUOT_W-2:0], dv_ge};
			end
			default: ;
		endcase
	end

	assign quot = quot_q;
	assign done = done_q;

endmodule

FILE: rtl/spp_dp.sv
module spp_dp import spp_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [DATA_W-1:0]      cfg_data,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tlast,
	input  logic [IN_TUSER_W-1:0]  s_tuser,
	input  logic                   m_tready,
	output logic                   m_tvalid,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tlast,
	input  spp_cmd_t               cmd,
	output spp_sts_t               sts
);

	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam logic [WIDTHF_W-1:0] W_MAX = WIDTHF_W'(MAX_WIDTH);

	// configuration
	logic [2:0]          pool_mode_q;
	logic [WIDTHF_W-1:0] row_width_q;
	logic [DATA_W-1:0]   fill_value_q;

	// sequence tracking
	logic [COLF_W-1:0]   column_pos_q;
	logic [ROW_W-1:0]    rows_q;
	logic [ROW_W-1:0]    grow_q;
	logic                empty_q;
	logic [WIDTHF_W-1:0] pad_k_q;

	// item in flight
	logic [WIDTHF_W-1:0] col_q;
	logic [DATA_W-1:0]   sample_q;
	logic                last_q;
	logic                first_q;
	logic [ROW_W-1:0]    n_q;
	logic [ROW_W-1:0]    idx_in_q;
	logic [ACC_W-1:0]    fin_acc_q;
	logic [ROW_W-1:0]    fin_idx_q;

	// output register
	logic                out_valid_q;
	logic [DATA_W-1:0]   pooled_q;
	logic [WIN_W-1:0]    winner_q;
	logic [COLF_W-1:0]   column_q;
	logic                done_q;

	logic [2:0]          mode;
	logic [WIDTHF_W-1:0] w_eff;
	logic                bs;
	logic [COLF_W-1:0]   col_base;
	logic [ROW_W-1:0]    rows_base;
	logic [ROW_W-1:0]    grow_base;
	logic [WIDTHF_W-1:0] col_in;
	logic                col_end;

	logic [ACC_W-1:0]    acc_rd;
	logic [ROW_W-1:0]    idx_rd;
	logic [ACC_W-1:0]    x64;
	logic [ACC_W-1:0]    sum;
	logic [ACC_W-1:0]    sat_sum;
	logic                gt;
	logic                lt;
	logic                w_one;
	logic [ACC_W-1:0]    acc_new;
	logic [ROW_W-1:0]    idx_new;

	logic                fin_neg;
	logic [ACC_W-1:0]    fin_mag;
	logic [DATA_W-1:0]   plain_val;
	logic [QUOT_W-1:0]   quot;
	logic                iter_done;
	logic                q_sat;
	logic [DATA_W-1:0]   iter_val;
	logic [WIN_W-1:0]    win_res;
	logic                plain;

	always_comb begin
		mode  = (pool_mode_q == MODE_UNUSED) ? MODE_SUM : pool_mode_q;
		plain = !(mode == MODE_AVG || mode == MODE_SQRT);
		if (row_width_q == '0) begin
			w_eff = WIDTHF_W'(1);
		end else if (row_width_q > W_MAX) begin
			w_eff = W_MAX;
		end else begin
			w_eff = row_width_q;
		end
		w_one = w_eff == WIDTHF_W'(1);
	end

	// accept-side view: a batch start clears the counters first
	always_comb begin
		bs        = s_tuser[USER_BATCH];
		col_base  = bs ? '0 : column_pos_q;
		rows_base = bs ? '0 : rows_q;
		grow_base = bs ? '0 : grow_q;
		if ({1'b0, col_base} >= w_eff) begin
			col_in = w_eff - WIDTHF_W'(1);
		end else begin
			col_in = {1'b0, col_base};
		end
		col_end = (col_in + WIDTHF_W'(1)) >= w_eff;
	end

	spp_ram #(.WIDTH(ACC_W), .DEPTH(MAX_WIDTH)) u_acc_ram (
		.clk   (clk),
		.we    (cmd.update),
		.waddr (col_q[COL_W-1:0]),
		.wdata (acc_new),
		.re    (cmd.accept),
		.raddr (col_in[COL_W-1:0]),
		.rdata (acc_rd)
	);

	spp_ram #(.WIDTH(ROW_W), .DEPTH(MAX_WIDTH)) u_idx_ram (
		.clk   (clk),
		.we    (cmd.update),
		.waddr (col_q[COL_W-1:0]),
		.wdata (idx_new),
		.re    (cmd.accept),
		.raddr (col_in[COL_W-1:0]),
		.rdata (idx_rd)
	);

	// column update
	always_comb begin
		x64     = {{(ACC_W-DATA_W){sample_q[DATA_W-1]}}, sample_q};
		sum     = acc_rd + x64;
		if ((acc_rd[ACC_W-1] == x64[ACC_W-1]) && (sum[ACC_W-1] != acc_rd[ACC_W-1])) begin
			sat_sum = x64[ACC_W-1] ? ACC_MIN : ACC_MAX;
		end else begin
			sat_sum = sum;
		end
		gt = $signed(x64) > $signed(acc_rd);
		lt = $signed(x64) < $signed(acc_rd);
		acc_new = acc_rd;
		idx_new = idx_rd;
		if (first_q) begin
			acc_new = x64;
			idx_new = idx_in_q;
		end else begin
			unique case (mode)
				MODE_SUM, MODE_AVG, MODE_SQRT: acc_new = sat_sum;
				MODE_MAX: begin
					if (w_one ? gt : !lt) begin
						acc_new = x64;
						idx_new = idx_in_q;
					end
				end
				MODE_MIN: begin
					if (w_one ? lt : !gt) begin
						acc_new = x64;
						idx_new = idx_in_q;
					end
				end
				MODE_LAST: begin
					acc_new = x64;
					idx_new = idx_in_q;
				end
				default: ;
			endcase
		end
	end

	// result shaping
	always_comb begin
		fin_neg = fin_acc_q[ACC_W-1];
		fin_mag = fin_neg ? (ACC_W'(0) - fin_acc_q) : fin_acc_q;
		if ((fin_acc_q[ACC_W-1:DATA_W-1] == '0) || (fin_acc_q[ACC_W-1:DATA_W-1] == '1)) begin
			plain_val = fin_acc_q[DATA_W-1:0];
		end else begin
			plain_val = fin_neg ? Q_MIN32 : Q_MAX32;
		end
		q_sat = |quot[QUOT_W-1:DATA_W-1];
		if (q_sat) begin
			iter_val = fin_neg ? Q_MIN32 : Q_MAX32;
		end else begin
			iter_val = fin_neg ? (DATA_W'(0) - quot[DATA_W-1:0]) : quot[DATA_W-1:0];
		end
		win_res = (mode == MODE_MAX || mode == MODE_MIN) ? {1'b0, fin_idx_q} : '0;
	end

	spp_iter u_iter (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.start_iter),
		.op_sqrt (mode == MODE_SQRT),
		.mag     (fin_mag),
		.n       (n_q),
		.quot    (quot),
		.done    (iter_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_mode_q  <= MODE_SUM;
			row_width_q  <= WIDTHF_W'(1);
			fill_value_q <= '0;
			column_pos_q <= '0;
			rows_q       <= '0;
			grow_q       <= '0;
			empty_q      <= 1'b0;
			pad_k_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_POOL_MODE:  pool_mode_q  <= cfg_data[2:0];
					CFG_ROW_WIDTH:  row_width_q  <= cfg_data[WIDTHF_W-1:0];
					CFG_FILL_VALUE: fill_value_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.accept) begin
				empty_q <= s_tuser[USER_EMPTY];
				pad_k_q <= '0;
				if (s_tuser[USER_EMPTY]) begin
					column_pos_q <= '0;
					rows_q       <= '0;
					grow_q       <= grow_base;
				end else if (col_end) begin
					column_pos_q <= '0;
					grow_q       <= grow_base + ROW_W'(1);
					if (s_tlast) begin
						rows_q <= '0;
					end else if (rows_base < ROWS_CAP) begin
						rows_q <= rows_base + ROW_W'(1);
					end else begin
						rows_q <= rows_base;
					end
				end else begin
					column_pos_q <= col_in[COLF_W-1:0] + COLF_W'(1);
					rows_q       <= rows_base;
					grow_q       <= grow_base;
				end
			end
			if (cmd.load_pad) begin
				pad_k_q <= pad_k_q + WIDTHF_W'(1);
			end
			if (cmd.load_pad || cmd.load_plain || cmd.load_iter) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			col_q    <= col_in;
			sample_q <= s_tdata;
			last_q   <= s_tlast;
			first_q  <= rows_base == '0;
			n_q      <= rows_base + ROW_W'(1);
			idx_in_q <= grow_base;
		end
		if (cmd.update) begin
			fin_acc_q <= acc_new;
			fin_idx_q <= idx_new;
		end
		if (cmd.load_pad) begin
			pooled_q <= fill_value_q;
			winner_q <= '1;
			column_q <= pad_k_q[COLF_W-1:0];
			done_q   <= pad_k_q == (w_eff - WIDTHF_W'(1));
		end else if (cmd.load_plain || cmd.load_iter) begin
			pooled_q <= cmd.load_iter ? iter_val : plain_val;
			winner_q <= win_res;
			column_q <= col_q[COLF_W-1:0];
			done_q   <= col_q == (w_eff - WIDTHF_W'(1));
		end
	end

	always_comb begin
		sts.in_empty  = s_tuser[USER_EMPTY];
		sts.last      = last_q;
		sts.plain     = plain;
		sts.iter_done = iter_done;
		sts.out_xfer  = out_valid_q && m_tready;
		sts.out_valid = out_valid_q;
		sts.pad_more  = empty_q && (pad_k_q != w_eff);
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, column_q, winner_q, pooled_q};
	assign m_tlast  = done_q;

endmodule

FILE: rtl/spp_ctrl.sv
module spp_ctrl import spp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  spp_sts_t sts,
	output spp_cmd_t cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) begin
				state_d = sts.in_empty ? ST_PAD : ST_UPD;
			end
			ST_UPD:  state_d = sts.last ? ST_FIN : ST_IDLE;
			ST_FIN:  state_d = sts.plain ? ST_EMIT : ST_WAIT;
			ST_WAIT: if (sts.iter_done) begin
				state_d = ST_EMIT;
			end
			ST_PAD:  state_d = ST_EMIT;
			ST_EMIT: if (sts.out_xfer) begin
				state_d = sts.pad_more ? ST_PAD : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready       = state_q == ST_IDLE;
		cmd.accept     = (state_q == ST_IDLE) && s_tvalid;
		cmd.update     = state_q == ST_UPD;
		cmd.start_iter = (state_q == ST_FIN) && !sts.plain;
		cmd.load_plain = (state_q == ST_FIN) && sts.plain;
		cmd.load_iter  = (state_q == ST_WAIT) && sts.iter_done;
		cmd.load_pad   = state_q == ST_PAD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_iter_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT) && sts.iter_done |=> state_q == ST_EMIT)
		else $error("divider result not forwarded to output");

	a_xfer_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		sts.out_xfer |-> state_q == ST_EMIT)
		else $error("output transfer outside emit state");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !sts.out_valid)
		else $error("result still pending while taking input");

endmodule

FILE: rtl/segmented_sequence_pooling.sv
// Segmented sequence pooling: rows of row_width signed Q16.16 elements stream in one element
// per transfer and are reduced column by column (sum, average, sum over sqrt(rows), max/min
// with winning global row, first, last); every element of a row marked tlast yields that
// column's saturated result, and an empty-sequence item yields row_width pad results with
// winner -1. One item is processed at a time: an element that does not produce a result is
// accepted, then its column is read-modify-written through the registered column store. A
// result element is also finished and handed to the output handshake: directly in sum/max/min/
// first/last modes, after the 80-step restoring divider in average, and after the 32-step root
// and then the divider in sqrt. An empty item is accepted, then each pad result is loaded and
// handed on; output stalls stretch each handshake. Config writes are accepted every cycle.
module segmented_sequence_pooling import spp_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// register write: index 0 pool_mode, 1 row_width, 2 empty-sequence fill value
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [DATA_W-1:0]      cfg_data,
	// input element stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // [31:0] sample
	input  logic                   s_tlast,  // row_last
	input  logic [IN_TUSER_W-1:0]  s_tuser,  // [0] empty_seq, [1] batch_start
	// pooled result stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // [31:0] pooled, [64:32] winner_row,
	                                         // [70:65] column, [71] zero
	output logic                   m_tlast   // seq_done
);

	spp_cmd_t cmd;
	spp_sts_t sts;

	// registers are plain flops, a write always lands
	assign cfg_ready = 1'b1;

	spp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	spp_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

FILE: bench/tb_top.sv
module tb_top;
	import spp_pkg::*;

	// One pooled column result: pooled value, winner row, column and sequence end.
	typedef struct {
		logic [DATA_W-1:0] pooled;
		logic [WIN_W-1:0] winner;
		logic [COLF_W-1:0] column;
		logic seq_done;
	} pool_result_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata;   // [31:0] sample
	logic s_tlast;                    // row_last
	logic [IN_TUSER_W-1:0] s_tuser;   // [0] empty_seq, [1] batch_start
	logic m_tvalid;
	logic m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;  // [31:0] pooled, [64:32] winner_row, [70:65] column, [71] zero
	logic m_tlast;                    // seq_done

	segmented_sequence_pooling dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	// Predictor state: mirrors the block's registers and per-column stores.
	logic [2:0] pm_mode;
	logic [6:0] pm_width;
	logic [31:0] pm_pad;
	logic signed [63:0] col_acc [64];
	logic [31:0] col_row [64];
	int unsigned col_pos;
	logic [31:0] seq_rows;
	logic [31:0] abs_row;

	pool_result_t pooled_q[$];
	int mismatches;
	int unexpected;
	longint cycles;
	bit long_hold;     // receiver held off entirely
	bit rx_calm;       // receiver always ready
	bit tx_steady;     // sender sends without gaps
	int cur_w;         // effective width for stimulus shaping

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Integer square root of a 64-bit value, bit by bit.
	function automatic logic [63:0] root64(input logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [31:0] clamp_q(input bit neg, input logic [63:0] m);
		if (neg) return (m >= 64'h8000_0000) ? Q_MIN32 : 32'(-m);
		return (m > 64'h7FFF_FFFF) ? Q_MAX32 : m[31:0];
	endfunction

	// Final value of one column for the current mode and row count n.
	function automatic logic [31:0] column_value(input logic [2:0] md,
			input logic signed [63:0] acc, input logic [63:0] n);
		bit neg;
		logic [63:0] m, s, q1, r1;
		neg = acc < 0;
		m = neg ? 64'(0 - acc) : 64'(acc);
		if (md == MODE_AVG) return clamp_q(neg, (m + n / 2) / n);
		if (md == MODE_SQRT) begin
			s = root64(n << 32);
			q1 = m / s;
			r1 = m % s;
			if (q1 >= 64'd32768) return clamp_q(neg, 64'd1 << 32);
			return clamp_q(neg, (q1 << 16) + ((r1 << 16) + s / 2) / s);
		end
		return clamp_q(neg, m);
	endfunction

	function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63]) return a[63] ? ACC_MIN : ACC_MAX;
		return s;
	endfunction

	// Advance the predictor by one accepted element and queue what it yields.
	task automatic predict_item(input logic [31:0] x, input bit last, input bit empty,
			input bit batch);
		int unsigned w, col;
		logic [2:0] md;
		logic signed [63:0] sx, a;
		bit take;
		pool_result_t r;
		w = (pm_width == 0) ? 1 : ((pm_width > 64) ? 64 : pm_width);
		md = (pm_mode == MODE_UNUSED) ? MODE_SUM : pm_mode;
		sx = {{32{x[31]}}, x};
		if (batch) begin
			abs_row = 0;
			col_pos = 0;
			seq_rows = 0;
		end
		if (empty) begin
			for (int k = 0; k < w; k++) begin
				r.pooled = pm_pad;
				r.winner = '1;
				r.column = k[5:0];
				r.seq_done = (k == w - 1);
				pooled_q.push_back(r);
			end
			col_pos = 0;
			seq_rows = 0;
			return;
		end
		col = (col_pos >= w) ? w - 1 : col_pos;
		if (seq_rows == 0) begin
			col_acc[col] = sx;
			col_row[col] = abs_row;
		end else if (md <= MODE_SQRT) begin
			col_acc[col] = add_sat(col_acc[col], sx);
		end else if (md == MODE_MAX || md == MODE_MIN) begin
			a = col_acc[col];
			if (md == MODE_MAX) take = (w == 1) ? (sx > a) : (sx >= a);
			else take = (w == 1) ? (sx < a) : (sx <= a);
			if (take) begin
				col_acc[col] = sx;
				col_row[col] = abs_row;
			end
		end else if (md == MODE_LAST) begin
			col_acc[col] = sx;
			col_row[col] = abs_row;
		end
		if (last) begin
			r.pooled = column_value(md, col_acc[col], 64'(seq_rows) + 1);
			r.winner = (md == MODE_MAX || md == MODE_MIN) ? {1'b0, col_row[col]} : '0;
			r.column = col[5:0];
			r.seq_done = (col == w - 1);
			pooled_q.push_back(r);
		end
		if (col + 1 >= w) begin
			col_pos = 0;
			abs_row = abs_row + 1;
			if (last) seq_rows = 0;
			else if (seq_rows < ROWS_CAP) seq_rows = seq_rows + 1;
		end else begin
			col_pos = col + 1;
		end
	endtask

	// Cycle counter and watchdog.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 3_000_000) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Result checker: every accepted transfer is compared with the oldest prediction.
	always @(posedge clk) begin
		pool_result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pooled_q.size() == 0) begin
				unexpected++;
				if (mismatches + unexpected <= 10) $display("unexpected result %h", m_tdata);
			end else begin
				e = pooled_q.pop_front();
				if (m_tdata[31:0] !== e.pooled || m_tdata[64:32] !== e.winner ||
						m_tdata[70:65] !== e.column || m_tlast !== e.seq_done ||
						m_tdata[71] !== 1'b0) begin
					mismatches++;
					if (mismatches + unexpected <= 10)
						$display("mismatch: exp pooled %h row %h col %0d done %b, got %h %h %0d %b",
							e.pooled, e.winner, e.column, e.seq_done,
							m_tdata[31:0], m_tdata[64:32], m_tdata[70:65], m_tlast);
				end
			end
		end
	end

	// Receiver stall pattern; a long hold-off is counted in cycles here as well.
	initial begin
		int hold;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				m_tready <= 1'b0;
				hold = 0;
				while (hold < 400) begin
					@(negedge clk);
					hold++;
				end
				long_hold = 1'b0;
			end else if (rx_calm) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= (($urandom & 7) < 5);
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_POOL_MODE: pm_mode = val[2:0];
			CFG_ROW_WIDTH: pm_width = val[6:0];
			CFG_FILL_VALUE: pm_pad = val;
			default: ;
		endcase
	endtask

	// Waits for every predicted result, then lets the slowest pipeline drain.
	task automatic drain;
		while (pooled_q.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic set_config(input logic [2:0] md, input int w, input logic [31:0] pad);
		int wf;
		idle_input();
		drain();
		write_reg(CFG_POOL_MODE, 32'(md));
		write_reg(CFG_ROW_WIDTH, w);
		write_reg(CFG_FILL_VALUE, pad);
		wf = int'(w[6:0]);
		cur_w = (wf == 0) ? 1 : ((wf > 64) ? 64 : wf);
	endtask

	// Sends one element; bursts with random gaps unless the sender is steady.
	task automatic send_item(input logic [31:0] x, input bit last, input bit empty,
			input bit batch);
		if (!tx_steady && ($urandom & 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_tdata <= x;
		s_tlast <= last;
		s_tuser <= {batch, empty};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predict_item(x, last, empty, batch);
		@(negedge clk);
	endtask

	task automatic idle_input;
		s_tvalid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 8) << 16;
			default: return $urandom;
		endcase
	endfunction

	// One sequence of nrows full rows with random content.
	task automatic send_sequence(input int nrows, input bit batch);
		for (int r = 0; r < nrows; r++)
			for (int c = 0; c < cur_w; c++)
				send_item(rand_sample(), r == nrows - 1, 1'b0, batch && r == 0 && c == 0);
	endtask

	// Directed: extremes of the samples, saturating sums, ties, empty items.
	task automatic test_directed;
		set_config(MODE_SUM, 1, 32'h1234_5678);
		send_item(32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1);
		send_item(32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0);
		send_item(32'h8000_0000, 1'b0, 1'b0, 1'b0);
		send_item(32'h8000_0000, 1'b1, 1'b0, 1'b0);
		send_item(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0);   // empty item, sample ignored
		set_config(MODE_MAX, 2, 32'h8000_0000);
		send_item(32'h0001_0000, 1'b0, 1'b0, 1'b0);   // tie on later row wins (width 2)
		send_item(32'h0000_0005, 1'b0, 1'b0, 1'b0);
		send_item(32'h0001_0000, 1'b1, 1'b0, 1'b0);
		send_item(32'h0000_0005, 1'b1, 1'b0, 1'b0);
		send_item(32'h0, 1'b0, 1'b1, 1'b1);           // empty with batch start
		set_config(MODE_MIN, 1, 32'h7FFF_FFFF);
		send_item(32'h0000_0003, 1'b0, 1'b0, 1'b1);   // tie on earlier row kept (width 1)
		send_item(32'h0000_0003, 1'b1, 1'b0, 1'b0);
		set_config(MODE_AVG, 3, 32'h0);
		send_item(32'h0000_0007, 1'b0, 1'b0, 1'b0);
		send_item(32'hFFFF_FFF9, 1'b1, 1'b0, 1'b0);   // row_last mid-row
		send_item(32'h0000_0001, 1'b1, 1'b0, 1'b0);
		send_item(32'h0000_0003, 1'b0, 1'b0, 1'b0);
		send_item(32'hFFFF_FFFD, 1'b1, 1'b0, 1'b0);
		send_item(32'h0000_0001, 1'b0, 1'b0, 1'b0);
		send_item(32'h0000_0001, 1'b1, 1'b0, 1'b0);
		idle_input();
	endtask

	// Partial sequences dropped by batch start and by empty items, and width shrink.
	task automatic test_drop_and_shrink;
		set_config(MODE_SQRT, 4, 32'hDEAD_BEEF);
		send_item(32'h0005_0000, 1'b0, 1'b0, 1'b1);
		send_item(32'h0005_0000, 1'b0, 1'b0, 1'b0);
		send_item(32'h0, 1'b0, 1'b0, 1'b1);           // batch start drops the partial row
		for (int c = 1; c < 4; c++) send_item(32'h0003_0000, 1'b0, 1'b0, 1'b0);
		send_item(32'h0, 1'b0, 1'b1, 1'b0);           // empty drops a partial sequence
		send_sequence(3, 1'b0);
		send_item(32'h0001_0000, 1'b0, 1'b0, 1'b0);
		send_item(32'h0002_0000, 1'b0, 1'b0, 1'b0);
		idle_input();
		drain();
		write_reg(CFG_ROW_WIDTH, 32'd1);              // position now beyond width
		cur_w = 1;
		send_item(32'h0004_0000, 1'b1, 1'b0, 1'b0);
		idle_input();
	endtask

	// Random sequences across every mode and a set of widths, extremes included.
	task automatic test_random(input int budget);
		int sent, n;
		int widths[6] = '{1, 2, 3, 7, 64, 0};
		sent = 0;
		while (sent < budget) begin
			// an open sequence is closed first, so a wider row never reads unwritten columns
			if (seq_rows != 0) begin
				send_item(32'h0, 1'b0, 1'b1, 1'b0);
				idle_input();
				sent++;
			end
			set_config(3'($urandom_range(0, 7)), widths[$urandom_range(0, 5)] +
				(($urandom & 7) == 0 ? 64 : 0), $urandom);
			for (int s = 0; s < 6 && sent < budget; s++) begin
				n = (cur_w == 64) ? 1 : $urandom_range(1, 4);
				case ($urandom_range(0, 9))
					0: begin
						send_item($urandom, 1'($urandom & 1), 1'b1, 1'($urandom & 1));
						sent++;
					end
					1: begin
						for (int k = 0; k < cur_w; k++)
							send_item($urandom, 1'($urandom & 1), 1'b0,
								k == 0 && ($urandom & 1));
						sent += cur_w;
					end
					default: begin
						send_sequence(n, ($urandom & 3) == 0);
						sent += n * cur_w;
					end
				endcase
			end
			idle_input();
		end
	endtask

	// Receiver held off while the sender keeps offering, then a steady run with the receiver always ready.
	task automatic test_backpressure;
		set_config(MODE_SUM, 8, 32'h0000_0001);
		long_hold = 1'b1;
		tx_steady = 1'b1;
		for (int k = 0; k < 4; k++) send_item($urandom, 1'b1, 1'b0, 1'b0);
		send_item(32'h0, 1'b0, 1'b1, 1'b0);
		send_item(32'h0, 1'b0, 1'b1, 1'b0);
		tx_steady = 1'b0;
		idle_input();
		while (pooled_q.size() != 0) @(negedge clk);
		rx_calm = 1'b1;
		tx_steady = 1'b1;
		set_config(MODE_LAST, 2, 32'h0);
		send_sequence(5, 1'b1);
		idle_input();
		rx_calm = 1'b0;
		tx_steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_POOL_MODE;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		s_tuser = '0;
		mismatches = 0;
		unexpected = 0;
		long_hold = 1'b0;
		rx_calm = 1'b0;
		tx_steady = 1'b0;
		pm_mode = MODE_SUM;
		pm_width = 1;
		pm_pad = '0;
		col_pos = 0;
		seq_rows = 0;
		abs_row = 0;
		cur_w = 1;
		for (int k = 0; k < 64; k++) begin
			col_acc[k] = 0;
			col_row[k] = 0;
		end
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_drop_and_shrink();
		test_backpressure();
		test_random(330);
		drain();

		if (mismatches == 0 && unexpected == 0 && pooled_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

FILE: files.f
rtl/spp_pkg.sv
rtl/spp_ram.sv
rtl/spp_iter.sv
rtl/spp_dp.sv
rtl/spp_ctrl.sv
rtl/segmented_sequence_pooling.sv
bench/tb_top.sv
